[rtl/mcwc_pkg.sv]
package mcwc_pkg;

  // Sizes and fixed protocol constants
  localparam int unsigned MAX_CHANNELS   = 8;
  localparam int unsigned CH_W           = 3;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned TL_W           = 31;
  localparam int unsigned RW_W           = 24;
  localparam int unsigned WIN_W          = 32;
  localparam int unsigned LEN_W          = 16;
  localparam int unsigned DUP_W          = 8;
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned SEGMENT_SIZE   = 1024;
  localparam int unsigned INITIAL_WINDOW = 2048;
  localparam int unsigned LOSS_WINDOW    = 1024;
  localparam int unsigned DUP_LIMIT      = 3;
  localparam int unsigned RW_RESET       = 65535;

  // Growth arithmetic widths
  localparam int unsigned X_W    = WIN_W + LEN_W;   // newly acked bytes times segment size
  localparam int unsigned SUM_W  = WIN_W + CH_W;    // sum of all windows
  localparam int unsigned PROD_W = WIN_W + X_W;     // max window times X
  localparam int unsigned SW     = WIN_W + 2;       // signed flight arithmetic

  localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_WINDOW = 2'd2;

  localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEND    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FINISH  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_SS    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CA    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FR    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   ack_channel;
    logic [TL_W-1:0]   ack_number;
  } req_t;

  typedef struct packed {
    logic              send_valid;
    logic [CH_W-1:0]   send_channel_id;
    logic [TL_W-1:0]   send_sequence;
    logic [LEN_W-1:0]  send_length;
    logic              finished;
    logic [MODE_W-1:0] mode;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [TL_W-1:0]      data;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_START,
    OP_FINISH,
    OP_ACK,
    OP_TIMEOUT,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_PICK,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_DIV_GO,
    OP_DIV_TAKE,
    OP_UPDATE,
    OP_EMIT,
    OP_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_COUPLED,
    DIV_TOTAL,
    DIV_WINDOW
  } div_sel_e;

  typedef struct packed {
    dp_op_e   op;
    div_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              done;
    logic              ch_ok;
    logic              scan_last;
    logic              div_done;
    logic              out_free;
  } sts_t;

endpackage

[rtl/mcwc_chan_if.sv]
interface mcwc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/mcwc_div.sv]
// Restoring divider, one quotient bit per cycle.
// rem_i must be below divisor_i (the upper part of a longer dividend).
module mcwc_div import mcwc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] rem_i,
  input  logic [X_W-1:0]   dividend_i,
  input  logic [SUM_W-1:0] divisor_i,
  output logic             done_o,
  output logic [X_W-1:0]   quot_o
);

  localparam int unsigned CW = $clog2(X_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [SUM_W-1:0] rem_q;
  logic [SUM_W-1:0] dvs_q;
  logic [X_W-1:0]   quo_q;
  logic [SUM_W:0]   sh;
  logic [SUM_W:0]   diff;
  logic             ge;

  always_comb begin
    sh   = {rem_q, quo_q[X_W-1]};
    diff = sh - {1'b0, dvs_q};
    ge   = sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(X_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[SUM_W-1:0] : sh[SUM_W-1:0];
      quo_q <= {quo_q[X_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[rtl/mcwc_dp.sv]
// Window control datapath: per-channel windows, transfer state, growth
// arithmetic and the result register.
module mcwc_dp import mcwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  input  req_t in_payload_i,
  input  logic cfg_valid_i,
  input  cfg_t cfg_i,
  output logic out_valid_o,
  output rsp_t out_payload_o,
  input  logic out_ready_i
);

  localparam logic signed [SW-1:0] SEG_S    = SW'(SEGMENT_SIZE);
  localparam logic signed [SW-1:0] FLOOR2_S = SW'(2 * SEGMENT_SIZE);
  localparam logic signed [SW-1:0] BIF_MAX  = SW'({1'b0, {(WIN_W-1){1'b1}}});
  localparam logic [WIN_W-1:0]     WIN_MAX  = '1;

  // configuration
  logic [TL_W-1:0]  tl_q;
  logic [CNT_W-1:0] cc_q;
  logic [RW_W-1:0]  rw_q;

  // transfer state
  logic [WIN_W-1:0]        cw_q [MAX_CHANNELS];
  logic [WIN_W-1:0]        ss_q [MAX_CHANNELS];
  logic [CH_W-1:0]         rr_q;
  logic [TL_W-1:0]         ha_q;
  logic [WIN_W-1:0]        nts_q;
  logic signed [WIN_W-1:0] bif_q;
  logic signed [WIN_W:0]   sf_q;
  logic [WIN_W-1:0]        nab_q;
  logic [MODE_W-1:0]       mode_q;
  logic [DUP_W-1:0]        dup_q;
  logic [TL_W-1:0]         la_q;
  logic                    done_q;

  // current request and work registers
  logic [KIND_W-1:0] kind_q;
  logic [CH_W-1:0]   ach_q;
  logic [TL_W-1:0]   num_q;
  logic [CH_W-1:0]   idx_q;
  logic [CH_W-1:0]   ch_q;
  logic [SUM_W-1:0]  total_q;
  logic [WIN_W-1:0]  maxw_q;
  logic [X_W-1:0]    x_q;
  logic [2*WIN_W-1:0] p_q;
  logic [X_W-1:0]    plo_q;
  logic [PROD_W-1:0] prod_q;
  logic              zero_q;
  logic [X_W-1:0]    q1_q;
  logic [X_W-1:0]    t1_q;
  logic [X_W-1:0]    t2_q;

  // pending segment and result register
  logic             seg_valid_q;
  logic [CH_W-1:0]  seg_ch_q;
  logic [TL_W-1:0]  seg_seq_q;
  logic [LEN_W-1:0] seg_len_q;
  logic             out_valid_q;
  rsp_t             out_q;

  logic [CNT_W-1:0] n_eff;
  logic [CH_W-1:0]  rd_idx;
  logic [WIN_W-1:0] cw_rd;
  logic [WIN_W-1:0] ss_rd;
  logic [WIN_W-1:0] rw32;
  logic [WIN_W-1:0] ha32;

  // divider hookup
  logic             div_start;
  logic [SUM_W-1:0] div_rem;
  logic [X_W-1:0]   div_dividend;
  logic [SUM_W-1:0] div_divisor;
  logic             div_done;
  logic [X_W-1:0]   div_quot;

  // ack / timeout
  logic signed [SW-1:0] b1, b1c, b2, t_rst, sf_sw, half, thr_to;
  logic [WIN_W-1:0]     thr_ack;
  logic [WIN_W:0]       nab_sum;
  logic [WIN_W-1:0]     nab_inc;
  logic [DUP_W-1:0]     dup_inc;
  logic                 ack_new;
  logic                 ack_credit;

  // send path
  logic [CNT_W:0]       rr_n;
  logic [CH_W-1:0]      rr_w;
  logic [X_W-1:0]       inc;
  logic [X_W:0]         cw_sum;
  logic [WIN_W-1:0]     cw_grown;
  logic [MODE_W-1:0]    mode_n;
  logic                 grow_en;
  logic [WIN_W-1:0]     lim;
  logic [WIN_W:0]       ms_sum;
  logic [WIN_W-1:0]     ms;
  logic                 can_send;
  logic [WIN_W-1:0]     rem_len;
  logic [LEN_W-1:0]     len_v;
  logic signed [SW-1:0] bif_sum;
  logic [WIN_W-1:0]     cw_init;

  always_comb begin
    if (cc_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (cc_q > CNT_W'(MAX_CHANNELS)) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = cc_q;
    end
  end

  // single read port into the window arrays
  always_comb begin
    case (cmd_i.op)
      OP_SCAN:             rd_idx = idx_q;
      OP_ACK, OP_TIMEOUT:  rd_idx = ach_q;
      default:             rd_idx = ch_q;
    endcase
  end

  assign cw_rd   = cw_q[rd_idx];
  assign ss_rd   = ss_q[rd_idx];
  assign rw32    = WIN_W'(rw_q);
  assign ha32    = WIN_W'(ha_q);
  assign cw_init = WIN_W'(n_eff) * WIN_W'(INITIAL_WINDOW);

  // ack and timeout arithmetic
  always_comb begin
    b1      = SW'(bif_q) - SEG_S;
    b1c     = b1[SW-1] ? '0 : b1;
    t_rst   = b1c + SEG_S;
    thr_ack = (t_rst > FLOOR2_S) ? t_rst[WIN_W-1:0] : FLOOR2_S[WIN_W-1:0];
    ack_new = num_q > la_q;
    sf_sw   = (dup_q == '0) ? (b1c + SEG_S) : SW'(sf_q);
    b2      = (dup_q == '0) ? (b1c - SEG_S) : b1c;
    dup_inc = (dup_q == '1) ? dup_q : dup_q + 1'b1;
    ack_credit = b2 <= ((sf_sw >>> 1) - SEG_S);
    nab_sum = {1'b0, nab_q} + (WIN_W+1)'(SEGMENT_SIZE);
    nab_inc = nab_sum[WIN_W] ? WIN_MAX : nab_sum[WIN_W-1:0];
    half    = (SW'(bif_q) + SEG_S) >>> 1;
    thr_to  = (half > FLOOR2_S) ? half : FLOOR2_S;
  end

  // send opportunity arithmetic
  always_comb begin
    rr_n     = (CNT_W+1)'(rr_q) + 1'b1;
    rr_w     = (rr_n >= {1'b0, n_eff}) ? '0 : rr_n[CH_W-1:0];
    inc      = zero_q ? '0 : ((t1_q < t2_q) ? t1_q : t2_q);
    cw_sum   = {1'b0, X_W'(cw_rd)} + {1'b0, inc};
    cw_grown = (cw_sum[X_W:WIN_W] != '0) ? WIN_MAX : cw_sum[WIN_W-1:0];
    if (mode_q != MODE_FR) begin
      mode_n = (cw_rd < ss_rd) ? MODE_SS : MODE_CA;
    end else begin
      mode_n = MODE_FR;
    end
    grow_en  = (mode_n != MODE_CA) || (nab_q >= cw_rd);
    lim      = (cw_rd < rw32) ? cw_rd : rw32;
    ms_sum   = {1'b0, ha32} + {1'b0, lim};
    ms       = ms_sum[WIN_W] ? WIN_MAX : ms_sum[WIN_W-1:0];
    can_send = (nts_q < ms) && (nts_q < WIN_W'(tl_q));
    rem_len  = WIN_W'(tl_q) - nts_q + 1'b1;
    len_v    = (rem_len > WIN_W'(SEGMENT_SIZE)) ? LEN_W'(SEGMENT_SIZE) : rem_len[LEN_W-1:0];
    bif_sum  = SW'(bif_q) + $signed(SW'(len_v));
  end

  // divider operand select, sampled on start only
  always_comb begin
    div_start = cmd_i.op == OP_DIV_GO;
    case (cmd_i.sel)
      DIV_COUPLED: begin
        div_rem      = SUM_W'(prod_q[PROD_W-1:X_W]);
        div_dividend = prod_q[X_W-1:0];
        div_divisor  = total_q;
      end
      DIV_TOTAL: begin
        div_rem      = '0;
        div_dividend = q1_q;
        div_divisor  = total_q;
      end
      default: begin
        div_rem      = '0;
        div_dividend = x_q;
        div_divisor  = SUM_W'(cw_rd);
      end
    endcase
  end

  mcwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_i      (div_rem),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q   <= '0;
      cc_q   <= CNT_W'(1);
      rw_q   <= RW_W'(RW_RESET);
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        cw_q[i] <= WIN_W'(INITIAL_WINDOW);
        ss_q[i] <= WIN_W'(RW_RESET);
      end
      rr_q        <= '0;
      ha_q        <= TL_W'(1);
      nts_q       <= WIN_W'(1);
      bif_q       <= '0;
      sf_q        <= '0;
      nab_q       <= '0;
      mode_q      <= MODE_SS;
      dup_q       <= '0;
      la_q        <= TL_W'(1);
      done_q      <= 1'b0;
      seg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_i.index)
          REG_TRANSFER_LENGTH: tl_q <= cfg_i.data;
          REG_CHANNEL_COUNT:   cc_q <= cfg_i.data[CNT_W-1:0];
          REG_RECEIVER_WINDOW: rw_q <= cfg_i.data[RW_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (cmd_i.op)
        OP_LATCH: begin
          seg_valid_q <= 1'b0;
        end
        OP_START: begin
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            cw_q[i] <= cw_init;
            ss_q[i] <= rw32;
          end
          rr_q   <= '0;
          ha_q   <= TL_W'(1);
          nts_q  <= WIN_W'(1);
          bif_q  <= '0;
          sf_q   <= '0;
          nab_q  <= '0;
          mode_q <= MODE_SS;
          dup_q  <= '0;
          la_q   <= TL_W'(1);
          done_q <= 1'b0;
        end
        OP_FINISH: begin
          done_q <= 1'b1;
        end
        OP_ACK: begin
          la_q <= num_q;
          if (ack_new) begin
            if (dup_q >= DUP_W'(DUP_LIMIT)) begin
              ss_q[ach_q] <= thr_ack;
              cw_q[ach_q] <= thr_ack;
              dup_q       <= '0;
              mode_q      <= MODE_RESET;
            end
            nab_q <= nab_inc;
            ha_q  <= num_q;
            bif_q <= b1c[WIN_W-1:0];
          end else begin
            if (dup_q == '0) begin
              mode_q <= MODE_FR;
            end
            sf_q  <= sf_sw[WIN_W:0];
            bif_q <= b2[WIN_W-1:0];
            dup_q <= dup_inc;
            if (dup_inc == DUP_W'(DUP_LIMIT)) begin
              nts_q <= WIN_W'(num_q);
            end
            if (ack_credit) begin
              nab_q <= nab_inc;
            end
          end
        end
        OP_TIMEOUT: begin
          ss_q[ach_q] <= thr_to[WIN_W-1:0];
          cw_q[ach_q] <= WIN_W'(LOSS_WINDOW);
          nts_q       <= WIN_W'(la_q);
        end
        OP_PICK: begin
          rr_q <= rr_w;
        end
        OP_UPDATE: begin
          mode_q <= mode_n;
          if ((mode_n == MODE_FR) && (dup_q == DUP_W'(DUP_LIMIT + 1))) begin
            nts_q <= ms;
          end
          if (grow_en) begin
            cw_q[ch_q] <= cw_grown;
            nab_q      <= '0;
          end
        end
        OP_EMIT: begin
          if (can_send) begin
            seg_valid_q <= 1'b1;
            bif_q       <= (bif_sum > BIF_MAX) ? BIF_MAX[WIN_W-1:0] : bif_sum[WIN_W-1:0];
            if (dup_q == DUP_W'(DUP_LIMIT)) begin
              nts_q <= ms;
            end else begin
              nts_q <= nts_q + WIN_W'(len_v);
            end
          end
        end
        OP_OUT: begin
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        kind_q    <= in_payload_i.kind;
        ach_q     <= in_payload_i.ack_channel;
        num_q     <= in_payload_i.ack_number;
        seg_ch_q  <= '0;
        seg_seq_q <= '0;
        seg_len_q <= '0;
      end
      OP_SCAN_INIT: begin
        idx_q   <= '0;
        total_q <= '0;
        maxw_q  <= '0;
      end
      OP_SCAN: begin
        idx_q   <= idx_q + 1'b1;
        total_q <= total_q + SUM_W'(cw_rd);
        if (cw_rd > maxw_q) begin
          maxw_q <= cw_rd;
        end
      end
      OP_PICK: begin
        ch_q <= rr_w;
      end
      OP_MUL1: begin
        x_q    <= X_W'(nab_q) * X_W'(SEGMENT_SIZE);
        p_q    <= (2*WIN_W)'(maxw_q) * (2*WIN_W)'(nab_q);
        zero_q <= (nab_q == '0) || (total_q == '0) || (cw_rd == '0);
      end
      OP_MUL2: begin
        plo_q <= X_W'(p_q[WIN_W-1:0]) * X_W'(SEGMENT_SIZE);
      end
      OP_MUL3: begin
        prod_q <= {X_W'(p_q[2*WIN_W-1:WIN_W]) * X_W'(SEGMENT_SIZE), {WIN_W{1'b0}}}
                  + PROD_W'(plo_q);
      end
      OP_DIV_TAKE: begin
        case (cmd_i.sel)
          DIV_COUPLED: q1_q <= div_quot;
          DIV_TOTAL:   t1_q <= div_quot;
          default:     t2_q <= div_quot;
        endcase
      end
      OP_EMIT: begin
        if (can_send) begin
          seg_ch_q  <= ch_q;
          seg_seq_q <= nts_q[TL_W-1:0];
          seg_len_q <= len_v;
        end
      end
      OP_OUT: begin
        out_q.send_valid      <= seg_valid_q;
        out_q.send_channel_id <= seg_ch_q;
        out_q.send_sequence   <= seg_seq_q;
        out_q.send_length     <= seg_len_q;
        out_q.finished        <= done_q;
        out_q.mode            <= mode_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.kind      = kind_q;
    sts_o.done      = done_q;
    sts_o.ch_ok     = {1'b0, ach_q} < n_eff;
    sts_o.scan_last = {1'b0, idx_q} == (n_eff - 1'b1);
    sts_o.div_done  = div_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

endmodule

[rtl/mcwc_ctrl.sv]
// Sequencer: steps the datapath through one request at a time.
module mcwc_ctrl import mcwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_PICK = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_MUL3 = 4'd6;
  localparam logic [3:0] S_D1GO = 4'd7;
  localparam logic [3:0] S_D1W  = 4'd8;
  localparam logic [3:0] S_D2GO = 4'd9;
  localparam logic [3:0] S_D2W  = 4'd10;
  localparam logic [3:0] S_D3GO = 4'd11;
  localparam logic [3:0] S_D3W  = 4'd12;
  localparam logic [3:0] S_UPD  = 4'd13;
  localparam logic [3:0] S_EMIT = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.sel   = DIV_COUPLED;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_OUT;
        case (sts_i.kind)
          KIND_START:  cmd_o.op = OP_START;
          KIND_FINISH: cmd_o.op = OP_FINISH;
          KIND_SEND: begin
            if (!sts_i.done) begin
              cmd_o.op = OP_SCAN_INIT;
              state_d  = S_SCAN;
            end
          end
          KIND_ACK: begin
            if (!sts_i.done && sts_i.ch_ok) begin
              cmd_o.op = OP_ACK;
            end
          end
          KIND_TIMEOUT: begin
            if (!sts_i.done && sts_i.ch_ok) begin
              cmd_o.op = OP_TIMEOUT;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (sts_i.scan_last) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.op = OP_PICK;
        state_d  = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = OP_MUL2;
        state_d  = S_MUL3;
      end
      S_MUL3: begin
        cmd_o.op = OP_MUL3;
        state_d  = S_D1GO;
      end
      S_D1GO: begin
        cmd_o.op = OP_DIV_GO;
        state_d  = S_D1W;
      end
      S_D1W: begin
        if (sts_i.div_done) begin
          cmd_o.op = OP_DIV_TAKE;
          state_d  = S_D2GO;
        end
      end
      S_D2GO: begin
        cmd_o.op  = OP_DIV_GO;
        cmd_o.sel = DIV_TOTAL;
        state_d   = S_D2W;
      end
      S_D2W: begin
        cmd_o.sel = DIV_TOTAL;
        if (sts_i.div_done) begin
          cmd_o.op = OP_DIV_TAKE;
          state_d  = S_D3GO;
        end
      end
      S_D3GO: begin
        cmd_o.op  = OP_DIV_GO;
        cmd_o.sel = DIV_WINDOW;
        state_d   = S_D3W;
      end
      S_D3W: begin
        cmd_o.sel = DIV_WINDOW;
        if (sts_i.div_done) begin
          cmd_o.op = OP_DIV_TAKE;
          state_d  = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.op = OP_UPDATE;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/multipath_congestion_window_control_unit.sv]
// Multipath congestion window control (coupled increase, LIA style). Each
// request is a start, send opportunity, ack, timeout or finish; every request
// returns exactly one result with the segment to send (if any), the finished
// flag and the current mode. Requests are handled one at a time. Start,
// finish, ack and timeout pass through the latch, dispatch and output states
// to the result register. A send opportunity sums and scans the windows of
// the n active channels, does split multiplies, then three back-to-back
// divisions on the shared restoring divider at one quotient bit (48 bits)
// per cycle. A new request is accepted once the previous one has been
// placed in the result register, even while that result still waits to be
// taken. Configuration writes are always accepted and are meant for idle
// time.
module multipath_congestion_window_control_unit import mcwc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  mcwc_chan_if.sink   req_i,
  mcwc_chan_if.source rsp_o,
  mcwc_chan_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;
  req_t req_payload;
  cfg_t cfg_payload;
  rsp_t rsp_payload;
  logic rsp_valid;

  assign req_payload = req_i.payload;
  assign cfg_payload = cfg_i.payload;

  // Register writes never stall.
  assign cfg_i.ready = 1'b1;

  // Sequencer: owns the request handshake, drives datapath commands.
  mcwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: window arrays, transfer state, divider, result register.
  mcwc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_payload_i  (req_payload),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_i         (cfg_payload),
    .out_valid_o   (rsp_valid),
    .out_payload_o (rsp_payload),
    .out_ready_i   (rsp_o.ready)
  );

  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp_payload;

`ifndef NO_ASSERTIONS
  // Only one request in work at a time.
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in work");

  // A result appears only after a request was worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(!req_i.ready))
    else $error("result raised straight from idle");

  // An emitted segment always carries bytes.
  a_segment_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.payload.send_valid) |-> (rsp_o.payload.send_length != '0))
    else $error("empty segment emitted");
`endif

endmodule
